>>> sv/stereo_subtitle_alpha_blend_defines.svh
// assertion helpers shared by the blend modules
// both sample on clk and are quiet while rst is high
`ifndef STEREO_SUBTITLE_ALPHA_BLEND_DEFINES_SVH
`define STEREO_SUBTITLE_ALPHA_BLEND_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define SSAB_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("ssab assertion failed");

// condition must hold in the cycle after the trigger
`define SSAB_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("ssab assertion failed");

`endif

>>> sv/ssab_pkg.sv
package ssab_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_OFFSET    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FALLBACK_OFFSET = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EYE_WIDTH       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EYE_HEIGHT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHROMA_HSHIFT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CHROMA_VSHIFT   = 3'd5;

  // register reset values
  localparam logic [11:0] EYE_WIDTH_RESET  = 12'd1920;
  localparam logic [11:0] EYE_HEIGHT_RESET = 12'd1080;

  // work queue between front and back
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_PTR_W;

  // bt.709 limited range coefficients, 8 fractional bits
  localparam logic [15:0] C_Y_R   = 16'd47;
  localparam logic [15:0] C_Y_G   = 16'd157;
  localparam logic [15:0] C_Y_B   = 16'd16;
  localparam logic [15:0] C_CB_R  = 16'd26;
  localparam logic [15:0] C_CB_G  = 16'd87;
  localparam logic [15:0] C_CB_B  = 16'd112;
  localparam logic [15:0] C_CR_R  = 16'd112;
  localparam logic [15:0] C_CR_G  = 16'd102;
  localparam logic [15:0] C_CR_B  = 16'd10;
  localparam logic [15:0] ROUND_HALF  = 16'd128;
  localparam logic [15:0] CHROMA_BIAS = 16'd32896;  // rounding plus 128 << 8
  localparam logic [7:0]  Y_OFFSET    = 8'd16;
  localparam logic [7:0]  ALPHA_FULL  = 8'd255;
  localparam logic [15:0] BLEND_ROUND = 16'd127;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [10:0] column;
    logic [10:0] row;
    logic        right_eye;
    logic [7:0]  luma_in;
    logic [7:0]  cb_in;
    logic [7:0]  cr_in;
  } pixel_t;

  typedef struct packed {
    logic        luma_write;
    logic [11:0] luma_column;
    logic [10:0] luma_row;
    logic [7:0]  luma_out;
    logic        chroma_write;
    logic [11:0] chroma_column;
    logic [10:0] chroma_row;
    logic [7:0]  cb_out;
    logic [7:0]  cr_out;
  } blend_t;

  // destination of one classified pixel
  typedef struct packed {
    logic        luma_write;
    logic [11:0] luma_column;
    logic [10:0] luma_row;
    logic        chroma_write;
    logic [11:0] chroma_column;
    logic [10:0] chroma_row;
  } dest_t;

  // one queue entry
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] luma_in;
    logic [7:0] cb_in;
    logic [7:0] cr_in;
    dest_t      dest;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> sv/stereo_subtitle_alpha_blend.sv
// stereo subtitle alpha blend
// pixel channel: one rgba subtitle pixel with its column, row, eye select and
// the destination luma/cb/cr samples; a transfer happens on a clock edge with
// pixel_valid high and pixel_stall low
// blend channel: one result per pixel, write enables and addresses for the
// luma and chroma planes plus blended samples; skipped pixels come out with
// every field zero, same order as the pixels went in
// config port: cfg_write with cfg_index and cfg_data, written while idle
// path: a transferred pixel goes through the queue, color convert, blend
// multiply and divide by 255 before it shows on the blend channel
// throughput: one pixel per cycle, set by the four deep back pipeline that
// moves every cycle unless the blend channel is stalled
// stall: a stall on the blend channel while blend_valid is high freezes the
// back pipeline; the work queue keeps taking pixels until its four entries
// are full, then pixel_stall rises
// reset: rst is synchronous, empties the queue and pipeline and loads the
// register reset values (eye 1920x1080, 4:2:0 chroma, no offsets)
module stereo_subtitle_alpha_blend
  import ssab_pkg::*;
#(
  parameter int MAX_EYE_WIDTH = 2048,
  parameter int MAX_HEIGHT    = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  // config writes
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // pixel channel
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  pixel_t                 pixel,
  // blend channel
  output logic                   blend_valid,
  input  logic                   blend_stall,
  output blend_t                 blend
);

  work_t         work;
  work_t         head;
  queue_status_t status;
  logic          push;
  logic          pop;

  // front: register file, eye shift and clip, chroma siting
  ssab_front #(
    .MAX_EYE_WIDTH (MAX_EYE_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .work      (work)
  );

  // stall depends only on queue fill, never on blend_stall directly
  assign pixel_stall = status.full;
  assign push        = pixel_valid && !status.full;

  // short queue decouples the classify side from the blend side
  ssab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (work),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  // back: color convert, blend, divide, output register
  ssab_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .status      (status),
    .pop         (pop),
    .blend_valid (blend_valid),
    .blend_stall (blend_stall),
    .blend       (blend)
  );

endmodule

>>> sv/ssab_front.sv
module ssab_front
  import ssab_pkg::*;
#(
  parameter int MAX_EYE_WIDTH = 2048,
  parameter int MAX_HEIGHT    = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  pixel_t                 pixel,
  output work_t                  work
);

  localparam logic [11:0] EW_CAP = (MAX_EYE_WIDTH > 4095) ? 12'hFFF : 12'(MAX_EYE_WIDTH);
  localparam logic [11:0] EH_CAP = (MAX_HEIGHT > 4095) ? 12'hFFF : 12'(MAX_HEIGHT);

  logic [8:0]  depth_offset;
  logic [7:0]  backup_offset;
  logic [11:0] eye_cols;
  logic [11:0] eye_rows;
  logic        chroma_hshift;
  logic        chroma_vshift;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_offset    <= '0;
      backup_offset   <= '0;
      eye_cols        <= EYE_WIDTH_RESET;
      eye_rows        <= EYE_HEIGHT_RESET;
      chroma_hshift   <= 1'b1;
      chroma_vshift   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEPTH_OFFSET:    depth_offset    <= cfg_data[8:0];
        REG_FALLBACK_OFFSET: backup_offset   <= cfg_data[7:0];
        REG_EYE_WIDTH:       eye_cols        <= cfg_data[11:0];
        REG_EYE_HEIGHT:      eye_rows        <= cfg_data[11:0];
        REG_CHROMA_HSHIFT:   chroma_hshift   <= cfg_data[0];
        REG_CHROMA_VSHIFT:   chroma_vshift   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [11:0] ew;
  logic [11:0] eh;
  logic [8:0]  shift;
  logic [12:0] dx;     // two's complement, bit 12 is the sign
  logic [12:0] dcol;
  logic        luma_due;
  logic        chroma_due;

  always_comb begin
    ew = (eye_cols > EW_CAP) ? EW_CAP : eye_cols;
    eh = (eye_rows > EH_CAP) ? EH_CAP : eye_rows;

    if (!pixel.right_eye) begin
      shift = '0;
    end else if (depth_offset != '0) begin
      shift = depth_offset;
    end else begin
      shift = {backup_offset[7], backup_offset};
    end

    dx   = {2'b00, pixel.column} + {{4{shift[8]}}, shift};
    dcol = (pixel.right_eye ? {1'b0, ew} : 13'd0) + dx;

    luma_due = (pixel.alpha != '0) && ({1'b0, pixel.row} < eh) && !dx[12]
               && (dx[11:0] < ew);
    chroma_due = luma_due && (!chroma_vshift || !pixel.row[0])
                 && (!chroma_hshift || !dx[0]);

    work.red     = pixel.red;
    work.green   = pixel.green;
    work.blue    = pixel.blue;
    work.alpha   = pixel.alpha;
    work.luma_in = pixel.luma_in;
    work.cb_in   = pixel.cb_in;
    work.cr_in   = pixel.cr_in;

    work.dest.luma_write   = luma_due;
    work.dest.luma_column  = luma_due ? dcol[11:0] : '0;
    work.dest.luma_row     = luma_due ? pixel.row : '0;
    work.dest.chroma_write = chroma_due;
    if (chroma_due) begin
      work.dest.chroma_column = chroma_hshift ? dcol[12:1] : dcol[11:0];
      work.dest.chroma_row    = chroma_vshift ? {1'b0, pixel.row[10:1]} : pixel.row;
    end else begin
      work.dest.chroma_column = '0;
      work.dest.chroma_row    = '0;
    end
  end

endmodule

>>> sv/ssab_queue.sv
`include "stereo_subtitle_alpha_blend_defines.svh"

module ssab_queue
  import ssab_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  work_t         push_item,
  input  logic          pop,
  output work_t         head,
  output queue_status_t status
);

  work_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head         = mem[rd_ptr];
  assign status.full  = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  `SSAB_ASSERT_NOW(a_count_bound, 1'b1, count <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
  `SSAB_ASSERT_NOW(a_no_pop_empty, pop, count != '0)
  `SSAB_ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + 1'b1)

endmodule

>>> sv/ssab_back.sv
`include "stereo_subtitle_alpha_blend_defines.svh"

module ssab_back
  import ssab_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  work_t         head,
  input  queue_status_t status,
  output logic          pop,
  output logic          blend_valid,
  input  logic          blend_stall,
  output blend_t        blend
);

  logic advance;

  // stage a: item taken from the queue
  logic  a_valid;
  work_t a_item;

  // stage b: converted color
  logic  b_valid;
  work_t b_item;
  logic [7:0] b_y, b_cb, b_cr;

  // stage c: weighted sums before the divide
  logic  c_valid;
  dest_t c_dest;
  logic [15:0] c_ny, c_ncb, c_ncr;

  assign advance = !blend_valid || !blend_stall;
  assign pop     = advance && !status.empty;

  logic [15:0] r16, g16, b16;
  logic [15:0] y_sum, cb_sum, cr_sum;

  always_comb begin
    r16    = {8'd0, a_item.red};
    g16    = {8'd0, a_item.green};
    b16    = {8'd0, a_item.blue};
    y_sum  = C_Y_R * r16 + C_Y_G * g16 + C_Y_B * b16 + ROUND_HALF;
    cb_sum = C_CB_B * b16 + CHROMA_BIAS - C_CB_R * r16 - C_CB_G * g16;
    cr_sum = C_CR_R * r16 + CHROMA_BIAS - C_CR_G * g16 - C_CR_B * b16;
  end

  logic [15:0] alpha16, inv16;
  logic [15:0] ny, ncb, ncr;

  always_comb begin
    alpha16 = {8'd0, b_item.alpha};
    inv16   = {8'd0, ALPHA_FULL - b_item.alpha};
    ny  = {8'd0, b_item.luma_in} * inv16 + {8'd0, b_y} * alpha16 + BLEND_ROUND;
    ncb = {8'd0, b_item.cb_in} * inv16 + {8'd0, b_cb} * alpha16 + BLEND_ROUND;
    ncr = {8'd0, b_item.cr_in} * inv16 + {8'd0, b_cr} * alpha16 + BLEND_ROUND;
  end

  // exact divide by 255 for sums below 65280
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [15:0] t;
    logic [15:0] s;
    t = n + 16'd1;
    s = t + {8'd0, t[15:8]};
    return s[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      blend_valid <= 1'b0;
    end else if (advance) begin
      a_valid     <= pop;
      b_valid     <= a_valid;
      c_valid     <= b_valid;
      blend_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_item <= head;
      b_item <= a_item;
      b_y    <= y_sum[15:8] + Y_OFFSET;
      b_cb   <= cb_sum[15:8];
      b_cr   <= cr_sum[15:8];
      c_dest <= b_item.dest;
      c_ny   <= ny;
      c_ncb  <= ncb;
      c_ncr  <= ncr;
      blend.luma_write    <= c_dest.luma_write;
      blend.luma_column   <= c_dest.luma_column;
      blend.luma_row      <= c_dest.luma_row;
      blend.luma_out      <= c_dest.luma_write ? div255(c_ny) : '0;
      blend.chroma_write  <= c_dest.chroma_write;
      blend.chroma_column <= c_dest.chroma_column;
      blend.chroma_row    <= c_dest.chroma_row;
      blend.cb_out        <= c_dest.chroma_write ? div255(c_ncb) : '0;
      blend.cr_out        <= c_dest.chroma_write ? div255(c_ncr) : '0;
    end
  end

  `SSAB_ASSERT_NEXT(a_pop_loads, pop, a_valid)
  `SSAB_ASSERT_NOW(a_chroma_needs_luma, blend_valid && blend.chroma_write, blend.luma_write)
  `SSAB_ASSERT_NOW(a_skip_zero, blend_valid && !blend.luma_write,
                   blend.luma_out == '0 && blend.cb_out == '0 && blend.cr_out == '0)

endmodule
